[rtl/btsc_pkg.sv]
`timescale 1ns / 1ps

package btsc_pkg;

  localparam int unsigned MSEC_W = 29;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_MASK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIME   = 1'b1;

  localparam logic [MSEC_W-1:0] MS_PER_HOUR   = 29'd3600000;
  localparam logic [MSEC_W-1:0] MS_PER_MINUTE = 29'd60000;
  localparam logic [MSEC_W-1:0] MS_PER_SECOND = 29'd1000;
  localparam logic [MSEC_W-1:0] VALUE_CEILING = 29'd359999999;

  typedef logic [MSEC_W-1:0] msec_t;

  typedef struct packed {
    msec_t      time_value;
    logic [6:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds_part;
    logic [9:0] millis_part;
  } fields_t;

  // load enables of the three front pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

endpackage

[rtl/btsc_in_if.sv]
`timescale 1ns / 1ps

interface btsc_in_if;
  import btsc_pkg::*;

  logic       valid;
  logic       ready;
  logic [2:0] action;
  msec_t      load_value;

  modport source (output valid, output action, output load_value, input ready);
  modport sink (input valid, input action, input load_value, output ready);

endinterface

[rtl/btsc_out_if.sv]
`timescale 1ns / 1ps

interface btsc_out_if;
  import btsc_pkg::*;

  logic       valid;
  logic       ready;
  msec_t      time_value;
  logic [6:0] hours;
  logic [5:0] minutes;
  logic [5:0] seconds_part;
  logic [9:0] millis_part;
  logic [1:0] cursor;
  logic       done_res;

  modport source (
    output valid, output time_value, output hours, output minutes,
    output seconds_part, output millis_part, output cursor, output done_res,
    input ready
  );
  modport sink (
    input valid, input time_value, input hours, input minutes,
    input seconds_part, input millis_part, input cursor, input done_res,
    output ready
  );

endinterface

[rtl/btsc_split.sv]
`timescale 1ns / 1ps

module btsc_split (
  input  logic              clk_i,
  input  btsc_pkg::msec_t   load_value_i,
  input  btsc_pkg::msec_t   max_time_i,
  input  btsc_pkg::pipe_en_t en_i,
  output btsc_pkg::fields_t fields_o
);
  import btsc_pkg::*;

  // Reciprocals for exact floor division after stripping the power-of-two
  // factor of each divisor: 3600000 = 28125 << 7, 60000 = 1875 << 5,
  // 1000 = 125 << 3.
  localparam logic [22:0] HOUR_RECIP = 23'd4886719;   // 2^37 / 28125, rounded up
  localparam logic [24:0] MIN_RECIP  = 25'd18325194;  // 2^35 / 1875, rounded up
  localparam logic [26:0] SEC_RECIP  = 27'd68719477;  // 2^33 / 125, rounded up

  msec_t       clamp;
  msec_t       v1_q;
  msec_t       v2_q;
  logic [6:0]  h2_q;
  logic [12:0] tmin2_q;
  logic [18:0] tsec2_q;
  logic [44:0] h_prod;
  logic [48:0] tmin_prod;
  logic [52:0] tsec_prod;
  logic [12:0] min_diff;
  logic [18:0] sec_diff;
  msec_t       ms_diff;
  fields_t     fields_q;

  always_comb begin
    clamp = load_value_i;
    if (clamp > max_time_i) begin
      clamp = max_time_i;
    end
    if (clamp > VALUE_CEILING) begin
      clamp = VALUE_CEILING;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      v1_q <= clamp;
    end
  end

  // whole hours, whole minutes and whole seconds of the value, in parallel
  assign h_prod    = 45'(v1_q[28:7]) * 45'(HOUR_RECIP);
  assign tmin_prod = 49'(v1_q[28:5]) * 49'(MIN_RECIP);
  assign tsec_prod = 53'(v1_q[28:3]) * 53'(SEC_RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      v2_q    <= v1_q;
      h2_q    <= h_prod[43:37];
      tmin2_q <= tmin_prod[47:35];
      tsec2_q <= tsec_prod[51:33];
    end
  end

  assign min_diff = tmin2_q - 13'(h2_q) * 13'd60;
  assign sec_diff = tsec2_q - 19'(tmin2_q) * 19'd60;
  assign ms_diff  = v2_q - 29'(tsec2_q) * 29'd1000;

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      fields_q.time_value   <= v2_q;
      fields_q.hours        <= h2_q;
      fields_q.minutes      <= min_diff[5:0];
      fields_q.seconds_part <= sec_diff[5:0];
      fields_q.millis_part  <= ms_diff[9:0];
    end
  end

  assign fields_o = fields_q;

endmodule

[rtl/button_time_setting_controller.sv]
`timescale 1ns / 1ps

// Button time-setting controller.
// in_i carries one button action per transfer (left, right, up, down, ok,
// load) with a millisecond load value; out_o returns one result per action:
// the time value after the action, its hours/minutes/seconds/millis split,
// the cursor and the done flag. Configuration (field enable mask, max_time)
// is written through cfg_we_i / cfg_idx_i / cfg_data_i while no action is
// in flight.
// A result becomes valid after its action passes the pipeline: the first
// of three front stages loads on the transfer, the stages split the load
// value into fields, and the state update writes the result register once
// the third stage holds the action and out_o can take it. Throughput: one
// action per cycle while out_o takes every result; the front stages are
// fully pipelined.
// Reset clears the time to zero, the cursor to hours, the done flag, and
// restores mask 15 and max_time 359999999.
// When out_o stalls, the result register holds; the front stages keep
// filling, so up to three more actions transfer in before in_i.ready drops.
module button_time_setting_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [btsc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  btsc_pkg::msec_t                   cfg_data_i,
  btsc_in_if.sink                           in_i,
  btsc_out_if.source                        out_o
);
  import btsc_pkg::*;

  localparam logic [2:0] ACT_LEFT  = 3'd0;
  localparam logic [2:0] ACT_RIGHT = 3'd1;
  localparam logic [2:0] ACT_UP    = 3'd2;
  localparam logic [2:0] ACT_DOWN  = 3'd3;
  localparam logic [2:0] ACT_OK    = 3'd4;
  localparam logic [2:0] ACT_LOAD  = 3'd5;

  localparam logic [1:0] FLD_HOURS   = 2'd0;
  localparam logic [1:0] FLD_MINUTES = 2'd1;
  localparam logic [1:0] FLD_SECONDS = 2'd2;
  localparam logic [1:0] FLD_MILLIS  = 2'd3;

  logic [3:0]  mask_q;
  msec_t       max_time_q;
  pipe_en_t    en;
  logic        en_out;
  logic [2:0]  stage_v_q;
  logic [2:0]  act1_q, act2_q, act3_q;
  logic        out_v_q;
  logic        upd;
  fields_t     ld_fields;

  msec_t       time_q, time_d;
  logic [6:0]  hrs_q, hrs_d;
  logic [5:0]  min_q, min_d;
  logic [5:0]  sec_q, sec_d;
  logic [9:0]  ms_q, ms_d;
  logic [1:0]  cur_q, cur_d;
  logic        done_q, done_d;

  msec_t       unit;
  logic [9:0]  fld;
  logic [9:0]  lim;
  logic        up_ok;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q     <= 4'd15;
      max_time_q <= VALUE_CEILING;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FIELD_MASK: mask_q <= cfg_data_i[3:0];
        CFG_MAX_TIME:   max_time_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its content moves on
  assign en_out = !out_v_q || out_o.ready;
  assign en.s3  = !stage_v_q[2] || en_out;
  assign en.s2  = !stage_v_q[1] || en.s3;
  assign en.s1  = !stage_v_q[0] || en.s2;
  assign upd    = en_out && stage_v_q[2];

  assign in_i.ready = en.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 3'b000;
      out_v_q   <= 1'b0;
    end else begin
      if (en.s1) stage_v_q[0] <= in_i.valid;
      if (en.s2) stage_v_q[1] <= stage_v_q[0];
      if (en.s3) stage_v_q[2] <= stage_v_q[1];
      if (en_out) out_v_q <= stage_v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.s1) act1_q <= in_i.action;
    if (en.s2) act2_q <= act1_q;
    if (en.s3) act3_q <= act2_q;
  end

  btsc_split u_split (
    .clk_i        (clk_i),
    .load_value_i (in_i.load_value),
    .max_time_i   (max_time_q),
    .en_i         (en),
    .fields_o     (ld_fields)
  );

  always_comb begin
    case (cur_q)
      FLD_HOURS: begin
        unit = MS_PER_HOUR;
        fld  = 10'(hrs_q);
        lim  = 10'd99;
      end
      FLD_MINUTES: begin
        unit = MS_PER_MINUTE;
        fld  = 10'(min_q);
        lim  = 10'd59;
      end
      FLD_SECONDS: begin
        unit = MS_PER_SECOND;
        fld  = 10'(sec_q);
        lim  = 10'd59;
      end
      default: begin
        unit = 29'd1;
        fld  = ms_q;
        lim  = 10'd999;
      end
    endcase
  end

  assign up_ok = (({1'b0, time_q} + {1'b0, unit}) <= {1'b0, max_time_q}) && (fld < lim);

  // Fields are kept split next to the value; a one-unit step never carries
  // across fields, so they stay consistent without a divide.
  always_comb begin
    time_d = time_q;
    hrs_d  = hrs_q;
    min_d  = min_q;
    sec_d  = sec_q;
    ms_d   = ms_q;
    cur_d  = cur_q;
    done_d = done_q;
    case (act3_q)
      ACT_LEFT: begin
        if (cur_q != FLD_HOURS) cur_d = cur_q - 2'd1;
      end
      ACT_RIGHT: begin
        if (cur_q != FLD_MILLIS && mask_q[cur_q + 2'd1]) cur_d = cur_q + 2'd1;
      end
      ACT_UP: begin
        if (up_ok) begin
          time_d = time_q + unit;
          case (cur_q)
            FLD_HOURS:   hrs_d = hrs_q + 7'd1;
            FLD_MINUTES: min_d = min_q + 6'd1;
            FLD_SECONDS: sec_d = sec_q + 6'd1;
            default:     ms_d  = ms_q + 10'd1;
          endcase
        end
      end
      ACT_DOWN: begin
        // hours nonzero is the same as value at least one hour
        if (fld != 10'd0) begin
          time_d = time_q - unit;
          case (cur_q)
            FLD_HOURS:   hrs_d = hrs_q - 7'd1;
            FLD_MINUTES: min_d = min_q - 6'd1;
            FLD_SECONDS: sec_d = sec_q - 6'd1;
            default:     ms_d  = ms_q - 10'd1;
          endcase
        end
      end
      ACT_OK: begin
        done_d = 1'b1;
      end
      ACT_LOAD: begin
        time_d = ld_fields.time_value;
        hrs_d  = ld_fields.hours;
        min_d  = ld_fields.minutes;
        sec_d  = ld_fields.seconds_part;
        ms_d   = ld_fields.millis_part;
        cur_d  = FLD_HOURS;
        done_d = 1'b0;
      end
      default: ;
    endcase
  end

  // the state doubles as the result register: it changes only on a transfer
  // into the output, which is blocked while a result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      hrs_q  <= '0;
      min_q  <= '0;
      sec_q  <= '0;
      ms_q   <= '0;
      cur_q  <= FLD_HOURS;
      done_q <= 1'b0;
    end else if (upd) begin
      time_q <= time_d;
      hrs_q  <= hrs_d;
      min_q  <= min_d;
      sec_q  <= sec_d;
      ms_q   <= ms_d;
      cur_q  <= cur_d;
      done_q <= done_d;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.time_value   = time_q;
  assign out_o.hours        = hrs_q;
  assign out_o.minutes      = min_q;
  assign out_o.seconds_part = sec_q;
  assign out_o.millis_part  = ms_q;
  assign out_o.cursor       = cur_q;
  assign out_o.done_res     = done_q;

`ifndef SYNTHESIS
  a_fields_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (32'(time_q) == 32'(hrs_q) * 32'd3600000 + 32'(min_q) * 32'd60000
                 + 32'(sec_q) * 32'd1000 + 32'(ms_q)))
    else $error("result fields do not add up to the time value");

  a_field_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (hrs_q <= 7'd99 && min_q <= 6'd59 && sec_q <= 6'd59 && ms_q <= 10'd999))
    else $error("result field out of range");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (stage_v_q == 3'b111 && out_v_q && !out_o.ready))
    else $error("input stalled while the pipeline has room");

  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd && act3_q == ACT_LOAD) |=> (cur_q == FLD_HOURS && !done_q && out_v_q))
    else $error("load did not clear cursor and done flag");
`endif

endmodule
